@@ sv/u2a_pkg.sv @@
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared constants, types and helpers for the number-to-text converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int HEX_DIGITS  = 8;

  // decimal digits needed for 2^VALUE_WIDTH-1 (1233/4096 ~ log10(2))
  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int NIBBLES    = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_LEN    = (NIBBLES > HEX_DIGITS) ? NIBBLES : HEX_DIGITS;
  localparam int MAX_DIGITS = (DEC_DIGITS > HEX_LEN) ? DEC_DIGITS : HEX_LEN;

  localparam int BCD_W = DEC_DIGITS * 4;
  localparam int DIG_W = MAX_DIGITS * 4;
  localparam int REM_W = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_X    = 7'h78;
  localparam logic [6:0] CHAR_A    = 7'h61;

  typedef struct packed {
    logic load;
    logic hex;
  } emit_cmd_t;

  function automatic logic [6:0] nib_to_char(input logic [3:0] n);
    logic [6:0] c;
    c = (n < 4'd10) ? (CHAR_ZERO + 7'(n)) : (CHAR_A + 7'(n) - 7'd10);
    return c;
  endfunction

endpackage

@@ sv/u2a_bcd.sv @@
// ----------------------------------------------------------------------------
// u2a_bcd
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module u2a_bcd (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [u2a_pkg::VALUE_WIDTH-1:0]   value,
  output logic                              done,
  output logic [u2a_pkg::BCD_W-1:0]         bcd
);
  import u2a_pkg::*;

  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [BCD_W-1:0]       adj;

  always_comb begin
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = bcd_r[i*4 +: 4];
      adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = value;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = sh_r << 1;
      bcd_nxt = {adj[BCD_W-2:0], sh_r[VALUE_WIDTH-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("conversion restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done raised while still shifting");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("bit counter ran out while busy");

endmodule

@@ sv/u2a_emit.sv @@
// ----------------------------------------------------------------------------
// u2a_emit
// Character serializer: shifts out one digit per cycle while the output is not
// stalled, skips leading zeros, adds the hex prefix and holds each character in an output register.
// ----------------------------------------------------------------------------
module u2a_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  u2a_pkg::emit_cmd_t          cmd,
  input  logic [u2a_pkg::DIG_W-1:0]   digits,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [6:0]                  out_char_code,
  output logic                        out_last_char
);
  import u2a_pkg::*;

  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] min_r, min_nxt;
  logic             pfx0_r, pfx0_nxt;
  logic             pfxx_r, pfxx_nxt;
  logic             busy_r, busy_nxt;
  logic             ov_r, ov_nxt;
  logic [6:0]       oc_r, oc_nxt;
  logic             ol_r, ol_nxt;
  logic [3:0]       nib;
  logic             pfx_act, skip, free, emit;

  assign nib     = dig_r[DIG_W-1 -: 4];
  assign pfx_act = pfx0_r | pfxx_r;
  assign skip    = busy_r && !pfx_act && (nib == 4'd0) && (rem_r > min_r);
  assign free    = !ov_r || !out_stall;
  assign emit    = busy_r && free && !skip;

  always_comb begin
    dig_nxt  = dig_r;
    rem_nxt  = rem_r;
    min_nxt  = min_r;
    pfx0_nxt = pfx0_r;
    pfxx_nxt = pfxx_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    oc_nxt   = oc_r;
    ol_nxt   = ol_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (cmd.load) begin
      dig_nxt  = digits;
      rem_nxt  = cmd.hex ? REM_W'(HEX_LEN) : REM_W'(DEC_DIGITS);
      min_nxt  = cmd.hex ? REM_W'(HEX_DIGITS) : REM_W'(1);
      pfx0_nxt = cmd.hex;
      pfxx_nxt = cmd.hex;
      busy_nxt = 1'b1;
    end else if (skip) begin
      dig_nxt = dig_r << 4;
      rem_nxt = rem_r - 1'b1;
    end else if (emit) begin
      ov_nxt = 1'b1;
      ol_nxt = 1'b0;
      if (pfx0_r) begin
        oc_nxt   = CHAR_ZERO;
        pfx0_nxt = 1'b0;
      end else if (pfxx_r) begin
        oc_nxt   = CHAR_X;
        pfxx_nxt = 1'b0;
      end else begin
        oc_nxt  = nib_to_char(nib);
        ol_nxt  = (rem_r == REM_W'(1));
        dig_nxt = dig_r << 4;
        rem_nxt = rem_r - 1'b1;
        // inner zeros are printed once a digit is out
        min_nxt = rem_r;
        if (rem_r == REM_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      pfx0_r <= 1'b0;
      pfxx_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      pfx0_r <= pfx0_nxt;
      pfxx_r <= pfxx_nxt;
    end
    dig_r <= dig_nxt;
    rem_r <= rem_nxt;
    min_r <= min_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = ov_r;
  assign out_char_code = oc_r;
  assign out_last_char = ol_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy_r) else $error("new text loaded while emitting");
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != '0) else $error("digit count empty while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !pfx_act && rem_r == REM_W'(1)) |=> (!busy_r && ov_r && ol_r))
    else $error("final digit did not close the text");

endmodule

@@ sv/unsigned_to_ascii_dec_hex.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_ascii_dec_hex
// Converts an unsigned number to ASCII decimal or 0x-prefixed hex text,
// one character per output transfer, most significant character first.
// ----------------------------------------------------------------------------
// path: hex digits load the serializer straight from the input transfer;
//   decimal digits come from the bit-serial BCD converter, then leading zeros are skipped
// throughput: one char per cycle unless out_stall holds it; a new input transfer
//   is taken once the last char of the previous number sits in the output
//   register
// reset: synchronous active-low rst_n returns to idle with no output pending
module unsigned_to_ascii_dec_hex (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [u2a_pkg::VALUE_WIDTH-1:0]   in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [6:0]                        out_char_code,
  output logic                              out_last_char
);
  import u2a_pkg::*;

  typedef enum logic {S_IDLE, S_CONV} state_t;

  state_t           state_r, state_nxt;
  logic             in_xfer;
  logic             bcd_start;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd_val;
  logic             emit_busy;
  emit_cmd_t        cmd;
  logic [DIG_W-1:0] digits;
  logic [DIG_W-1:0] hex_dig;
  logic [DIG_W-1:0] dec_dig;

  assign in_stall  = (state_r != S_IDLE) || emit_busy;
  assign in_xfer   = in_valid && !in_stall;
  assign bcd_start = in_xfer && !in_func;

  assign hex_dig = DIG_W'(in_value) << ((MAX_DIGITS - HEX_LEN) * 4);
  assign dec_dig = DIG_W'(bcd_val) << ((MAX_DIGITS - DEC_DIGITS) * 4);

  always_comb begin
    cmd.load = (in_xfer && in_func) || bcd_done;
    cmd.hex  = !bcd_done;
    digits   = bcd_done ? dec_dig : hex_dig;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (bcd_start) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  u2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .value (in_value),
    .done  (bcd_done),
    .bcd   (bcd_val)
  );

  u2a_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .digits        (digits),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unsigned_to_ascii_dec_hex. Directed and random
// numbers go in through the input channel with random gaps. A scoreboard
// builds the text that each accepted number should give and compares every
// output character and its end mark in order. One long receiver hold-off
// makes the converter back up and stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  import u2a_pkg::*;

  localparam bit FUNC_DEC = 1'b0;
  localparam bit FUNC_HEX = 1'b1;

  localparam bit [6:0] ASC_ZERO = 7'h30;
  localparam bit [6:0] ASC_X    = 7'h78;
  localparam bit [6:0] ASC_A    = 7'h61;

  localparam int RANDOM_NUMBERS = 240;
  localparam int MAX_GAP        = 6;
  localparam int HOLD_AT        = 40;
  localparam int LONG_HOLD      = 250;
  localparam int DRAIN_CYCLES   = 64;
  localparam int IDLE_LIMIT     = 3000;

  typedef struct packed {
    bit [6:0] code;
    bit       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t expected_text[$];
    int         numbers_dec;
    int         numbers_hex;
    int         chars_checked;
    int         errors;

    function new();
      numbers_dec   = 0;
      numbers_hex   = 0;
      chars_checked = 0;
      errors        = 0;
    endfunction

    function void note_number(bit func, bit [VALUE_WIDTH-1:0] value);
      bit [6:0]             digits[$];
      bit [VALUE_WIDTH-1:0] rest;
      int                   d;
      text_char_t           c;
      rest = value;
      while (digits.size() == 0 || rest != 0 ||
             (func == FUNC_HEX && digits.size() < HEX_DIGITS)) begin
        if (func == FUNC_HEX) begin
          d    = rest[3:0];
          rest = rest >> 4;
        end else begin
          d    = rest % 10;
          rest = rest / 10;
        end
        digits.push_front((d < 10) ? ASC_ZERO + 7'(d) : ASC_A + 7'(d - 10));
      end
      if (func == FUNC_HEX) begin
        numbers_hex++;
        c.last = 1'b0;
        c.code = ASC_ZERO;
        expected_text.push_back(c);
        c.code = ASC_X;
        expected_text.push_back(c);
      end else begin
        numbers_dec++;
      end
      foreach (digits[i]) begin
        c.code = digits[i];
        c.last = (i == digits.size() - 1);
        expected_text.push_back(c);
      end
    endfunction

    function void check_char(bit [6:0] code, bit last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char, expected none, actual code %h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      chars_checked++;
      if (code != want.code) begin
        $display("%0t: char_code mismatch, expected %h actual %h",
                 $time, want.code, code);
        errors++;
      end
      if (last != want.last) begin
        $display("%0t: last_char mismatch, expected %b actual %b",
                 $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic                   in_func       = 1'b0;
  logic [VALUE_WIDTH-1:0] in_value      = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [6:0]             out_char_code;
  logic                   out_last_char;

  text_scoreboard sb;

  bit                     tx_quiet = 1'b0;
  bit                     rx_quiet = 1'b0;
  int                     rx_total = 0;
  int                     rx_wait;
  int                     idle_cycles = 0;
  bit [VALUE_WIDTH-1:0]   pow10[10];

  unsigned_to_ascii_dec_hex dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  always #5 clk = ~clk;

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int next_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // holds the payload until the transfer; valid stays high when no gap follows
  task automatic send_number(bit func, bit [VALUE_WIDTH-1:0] value);
    int gap;
    gap = next_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_number(func, value);
  endtask

  function automatic bit [VALUE_WIDTH-1:0] random_value();
    bit [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 999);
      1: v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      2: v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      rx_wait = (rx_total == HOLD_AT) ? LONG_HOLD : next_gap(rx_quiet);
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        repeat (rx_wait) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) @(posedge clk);
      sb.check_char(out_char_code, out_last_char);
      rx_total++;
      if (rx_total % 24 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    sb = new();
    pow10[0] = 1;
    for (int k = 1; k < 10; k++) pow10[k] = pow10[k-1] * 10;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, extremes, digit-count boundaries, all hex letters
    send_number(FUNC_DEC, 32'd0);
    send_number(FUNC_HEX, 32'd0);
    send_number(FUNC_DEC, 32'hFFFF_FFFF);
    send_number(FUNC_HEX, 32'hFFFF_FFFF);
    send_number(FUNC_DEC, 32'd1);
    send_number(FUNC_HEX, 32'd1);
    send_number(FUNC_DEC, 32'd9);
    send_number(FUNC_DEC, 32'd10);
    send_number(FUNC_DEC, 32'd99);
    send_number(FUNC_DEC, 32'd100);
    send_number(FUNC_DEC, 32'd999_999_999);
    send_number(FUNC_DEC, 32'd1_000_000_000);
    send_number(FUNC_DEC, 32'h8000_0000);
    send_number(FUNC_HEX, 32'h8000_0000);
    send_number(FUNC_HEX, 32'hDEAD_BEEF);
    send_number(FUNC_HEX, 32'h0123_4567);
    send_number(FUNC_HEX, 32'h89AB_CDEF);
    send_number(FUNC_HEX, 32'h0000_000F);
    send_number(FUNC_DEC, 32'h5555_5555);
    send_number(FUNC_DEC, 32'hAAAA_AAAA);
    send_number(FUNC_HEX, 32'h5555_5555);
    send_number(FUNC_HEX, 32'hAAAA_AAAA);

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n % 20 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
      send_number(1'($urandom_range(0, 1)), random_value());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d decimal, %0d hex), %0d characters checked",
             sb.numbers_dec + sb.numbers_hex, sb.numbers_dec, sb.numbers_hex,
             sb.chars_checked);
    $display("with random gaps on both channels and a %0d-cycle output hold-off",
             LONG_HOLD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/u2a_pkg.sv
sv/u2a_bcd.sv
sv/u2a_emit.sv
sv/unsigned_to_ascii_dec_hex.sv
sim/tb_top.sv
